FILE: rtl/bpa_pkg.sv
// Shared types, constants and commands for the bitmap page allocator.
package bpa_pkg;

   // Byte address width and page geometry
   localparam int ADDR_W         = 22;
   localparam int PAGE_BYTES     = 4096;
   localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
   localparam int PAGE_W         = ADDR_W - PAGE_SHIFT;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W     = ((ADDR_W + 7) / 8) * 8;
   localparam int RSP_DATA_W     = ((ADDR_W + 7) / 8) * 8;
   localparam int REQ_USER_W     = 2;

   // Default bitmap geometry
   localparam int WORD_BITS_DEF  = 32;
   localparam int NUM_WORDS_DEF  = 32;

   // Request codes; the fourth code is unused, changes nothing and still gets a response
   typedef enum logic [REQ_USER_W-1:0] {
      REQ_ALLOC = 2'd0,
      REQ_MARK  = 2'd1,
      REQ_FREE  = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_REM,
      ST_UPD,
      ST_SCAN,
      ST_AWR,
      ST_DONE
   } ctl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic clr_step;     // write zero to the next bitmap word
      logic accept;       // latch request, clear result
      logic scan_step;    // issue next bitmap read of the scan
      logic div_step;     // word index from page number
      logic rem_step;     // bit index, read target word
      logic upd_write;    // write back marked or freed word
      logic alloc_write;  // write back word with new used bit
      logic set_nf;       // flag allocate failure
      logic rsp_load;     // move result into output register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_last;     // clearing pass is at its last word
      logic found;        // scanned word holds a free page
      logic scan_last;    // last bitmap word checked
      logic rsp_busy;     // output register still full
   } dp_sts_type;

endpackage

FILE: rtl/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpa_ram
   import bpa_pkg::*;
#(
   parameter int WIDTH = WORD_BITS_DEF,
   parameter int DEPTH = NUM_WORDS_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: rtl/bpa_ctl.sv
// Controller state machine of the bitmap page allocator.
module bpa_ctl
   import bpa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  dp_sts_type            sts,
   output dp_cmd_type            cmd,
   output ctl_state_type         state
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               unique case (req_tuser) inside
                  REQ_ALLOC:          state_in = ST_SCAN;
                  REQ_MARK, REQ_FREE: state_in = ST_DIV;
                  default:            state_in = ST_DONE;
               endcase
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = ST_REM;
         end
         ST_REM: begin
            cmd.rem_step = 1'b1;
            state_in     = ST_UPD;
         end
         ST_UPD: begin
            cmd.upd_write = 1'b1;
            state_in      = ST_DONE;
         end
         ST_SCAN: begin
            // stop stepping as soon as a free page shows up
            if (sts.found) begin
               state_in = ST_AWR;
            end else if (sts.scan_last) begin
               cmd.set_nf = 1'b1;
               state_in   = ST_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_AWR: begin
            cmd.alloc_write = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign state = state_ff;

endmodule

FILE: rtl/bpa_dp.sv
// Datapath of the bitmap page allocator: bitmap RAM, scan, index math, result.
module bpa_dp
   import bpa_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF,
   parameter int NUM_WORDS = NUM_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   localparam int IW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int PTW        = $clog2(NUM_WORDS + 1);
   localparam int BW         = $clog2(WORD_BITS);
   localparam int TOTAL      = NUM_WORDS * WORD_BITS;
   localparam int ADDR_PAGES = 1 << PAGE_W;
   localparam int PAGE_LIMIT = (TOTAL < ADDR_PAGES) ? TOTAL : ADDR_PAGES;
   localparam int PGW        = $clog2(TOTAL + 1);
   // page / WORD_BITS as multiply by rounded-up reciprocal, exact for PAGE_W bits
   localparam int SH         = PAGE_W + BW;
   localparam longint RECIP  = ((longint'(1) << SH) + WORD_BITS - 1) / WORD_BITS;
   localparam int RW         = PAGE_W + 2;
   localparam int PRW        = PAGE_W + RW;

   // bitmap RAM ports
   logic                 ram_we;
   logic [IW-1:0]        ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [IW-1:0]        ram_raddr;
   logic [WORD_BITS-1:0] ram_rdata;

   // clearing pass
   logic [IW-1:0]        clr_ptr_ff;

   // request
   logic [PAGE_W-1:0]    page_ff;
   logic                 set_ff;
   logic                 range_ff;
   logic [PAGE_W-1:0]    q_ff;
   logic [BW-1:0]        bit_ff;
   logic [PRW-1:0]       prod;
   logic [PAGE_W-1:0]    qmul;

   // scan
   logic [PTW-1:0]       ptr_ff;
   logic [PGW-1:0]       ptr_base_ff;
   logic                 chk_vld_ff;
   logic [IW-1:0]        chk_idx_ff;
   logic [PGW-1:0]       chk_base_ff;
   logic [WORD_BITS-1:0] free_bits;
   logic [BW-1:0]        enc;
   logic [PGW-1:0]       page_hit;
   logic [PGW+PAGE_SHIFT-1:0] addr_hit;

   // found word and result
   logic [WORD_BITS-1:0] wr_word_ff;
   logic [IW-1:0]        wr_idx_ff;
   logic [ADDR_W-1:0]    res_addr_ff;
   logic                 res_nf_ff;
   logic                 rsp_valid_ff;
   logic [ADDR_W-1:0]    rsp_addr_ff;
   logic                 rsp_nf_ff;

   bpa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // lowest free, addressable page of the word just read
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         free_bits[b] = !ram_rdata[b] &&
                        ((32'(chk_base_ff) + 32'(b)) < 32'(PAGE_LIMIT));
      end
      enc = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            enc = BW'(b);
         end
      end
      page_hit = chk_base_ff + PGW'(enc);
      addr_hit = {page_hit, {PAGE_SHIFT{1'b0}}};
   end

   assign prod = PRW'(page_ff) * PRW'(RECIP);
   assign qmul = q_ff * PAGE_W'(WORD_BITS);

   // RAM access steering
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = clr_ptr_ff;
      ram_wdata = '0;
      if (cmd.clr_step) begin
         ram_we = 1'b1;
      end else if (cmd.upd_write) begin
         ram_we    = range_ff;
         ram_waddr = IW'(q_ff);
         ram_wdata = ram_rdata;
         ram_wdata[bit_ff] = set_ff;
      end else if (cmd.alloc_write) begin
         ram_we    = 1'b1;
         ram_waddr = wr_idx_ff;
         ram_wdata = wr_word_ff;
      end
      ram_raddr = cmd.rem_step ? IW'(q_ff) : ptr_ff[IW-1:0];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff   <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_ptr_ff <= clr_ptr_ff + 1'b1;
         end
         // read data is checked only in the cycle right after its scan step
         chk_vld_ff <= cmd.scan_step && (ptr_ff < PTW'(NUM_WORDS));
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         page_ff     <= req_tdata[ADDR_W-1:PAGE_SHIFT];
         set_ff      <= (req_tuser == REQ_MARK);
         ptr_ff      <= '0;
         ptr_base_ff <= '0;
         res_addr_ff <= '0;
         res_nf_ff   <= 1'b0;
      end
      if (cmd.scan_step) begin
         ptr_ff      <= ptr_ff + 1'b1;
         ptr_base_ff <= ptr_base_ff + PGW'(WORD_BITS);
         chk_idx_ff  <= ptr_ff[IW-1:0];
         chk_base_ff <= ptr_base_ff;
      end
      if (cmd.div_step) begin
         q_ff     <= PAGE_W'(prod >> SH);
         range_ff <= (32'(page_ff) < 32'(TOTAL));
      end
      if (cmd.rem_step) begin
         bit_ff <= BW'(page_ff - qmul);
      end
      if (sts.found) begin
         wr_word_ff  <= ram_rdata | (WORD_BITS'(1) << enc);
         wr_idx_ff   <= chk_idx_ff;
         res_addr_ff <= ADDR_W'(addr_hit);
      end
      if (cmd.set_nf) begin
         res_nf_ff <= 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_addr_ff <= res_addr_ff;
         rsp_nf_ff   <= res_nf_ff;
      end
   end

   assign sts.clr_last  = (clr_ptr_ff == IW'(NUM_WORDS - 1));
   assign sts.found     = chk_vld_ff && (free_bits != '0);
   assign sts.scan_last = chk_vld_ff && (chk_idx_ff == IW'(NUM_WORDS - 1));
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_addr_ff);
   assign rsp_tuser  = rsp_nf_ff;

endmodule

FILE: rtl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: controller plus datapath.
// Allocate: bitmap words are read one per cycle from word 0 until a word with
// a free page turns up or the last word is checked, which gives none_free.
// Mark and free: word/bit index math, one read, one write (none for a page
// beyond the bitmap). One request at a time; the next is taken as soon as
// the result is in the output register. Reset is synchronous, active high,
// and starts a clearing pass that zeroes the bitmap while req_tready stays low.
module bitmap_page_allocator
   import bpa_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF,
   parameter int NUM_WORDS = NUM_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [21:0] page_address, rest zero
   input  logic [REQ_USER_W-1:0] req_tuser,  // [1:0] req_type
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [21:0] page_address_out, rest zero
   output logic                  rsp_tuser   // [0] none_free
);

   dp_cmd_type    cmd;
   dp_sts_type    sts;
   ctl_state_type state;

   // sequence clearing, scan and read-modify-write of the bitmap
   bpa_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd),
      .state      (state)
   );

   // hold the bitmap, find the lowest free page, build the result word
   bpa_dp #(
      .WORD_BITS (WORD_BITS),
      .NUM_WORDS (NUM_WORDS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   // a failed allocate never carries an address
   a_nf_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("none_free result with nonzero address");

   // one request in flight: accept drops ready in the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in work");

   // results are page aligned
   a_page_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[PAGE_SHIFT-1:0] == '0)
      else $error("result address not page aligned");

   // bitmap update and allocate writes come only from the ST_UPD or ST_AWR state
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_write || cmd.upd_write |-> state == ST_AWR || state == ST_UPD)
      else $error("bitmap write from unexpected state");
`endif

endmodule

FILE: tb/sv/bitmap_page_allocator_checker.sv
// Result checker for the bitmap page allocator: tracks the page bitmap and compares each response.
`timescale 1ns / 1ps

module bitmap_page_allocator_checker
   import bpa_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF,
   parameter int NUM_WORDS = NUM_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [21:0] page_address
   input  logic [REQ_USER_W-1:0] req_tuser,   // [1:0] req_type
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [21:0] page_address_out
   input  logic                  rsp_tuser,   // [0] none_free
   output int                    mismatches,
   output int                    pending
);

   localparam int TOTAL_PAGES = WORD_BITS * NUM_WORDS;

   typedef struct packed {
      logic [ADDR_W-1:0] page_addr;
      logic              none_free;
   } page_grant_type;

   logic [WORD_BITS-1:0] used_map [NUM_WORDS];
   page_grant_type       grant_q [$];
   int                   error_total = 0;

   function automatic bit page_in_reach(input longint page);
      return page < TOTAL_PAGES && page * PAGE_BYTES < (64'd1 << ADDR_W);
   endfunction

   // Apply one request to the bitmap and return the response it must produce.
   function automatic page_grant_type serve_request(input logic [REQ_USER_W-1:0] kind,
                                                    input logic [ADDR_W-1:0]     addr);
      page_grant_type grant;
      longint         page;
      bit             hit;
      grant = '0;
      hit   = 1'b0;
      page  = longint'(addr) / PAGE_BYTES;
      if (kind == REQ_ALLOC) begin
         for (longint p = 0; p < TOTAL_PAGES; p++) begin
            if (!hit && page_in_reach(p) && !used_map[p / WORD_BITS][p % WORD_BITS]) begin
               hit = 1'b1;
               used_map[p / WORD_BITS][p % WORD_BITS] = 1'b1;
               grant.page_addr = ADDR_W'(p * PAGE_BYTES);
            end
         end
         grant.none_free = !hit;
      end else if (kind == REQ_MARK && page_in_reach(page)) begin
         used_map[page / WORD_BITS][page % WORD_BITS] = 1'b1;
      end else if (kind == REQ_FREE && page_in_reach(page)) begin
         used_map[page / WORD_BITS][page % WORD_BITS] = 1'b0;
      end
      return grant;
   endfunction

   always @(posedge clock) begin
      page_grant_type want;
      if (reset) begin
         for (int w = 0; w < NUM_WORDS; w++) used_map[w] = '0;
         grant_q.delete();
      end else begin
         // compare the response first: a request taken on this edge cannot answer yet
         if (rsp_tvalid && rsp_tready) begin
            if (grant_q.size() == 0) begin
               error_total++;
               $display("%0t unexpected response: expected none, actual addr %h none_free %b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = grant_q.pop_front();
               if (rsp_tdata !== RSP_DATA_W'(want.page_addr)) begin
                  error_total++;
                  $display("%0t page_address_out mismatch: expected %h, actual %h",
                           $time, RSP_DATA_W'(want.page_addr), rsp_tdata);
               end
               if (rsp_tuser !== want.none_free) begin
                  error_total++;
                  $display("%0t none_free mismatch: expected %b, actual %b",
                           $time, want.none_free, rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready)
            grant_q.push_back(serve_request(req_tuser, req_tdata[ADDR_W-1:0]));
      end
      mismatches <= error_total;
      pending    <= grant_q.size();
   end

endmodule

FILE: tb/sv/bitmap_page_allocator_test.sv
// Top of the bitmap page allocator testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module bitmap_page_allocator_test;
   import bpa_pkg::*;

   // The fourth request code has no name in the package; it must be a no-op.
   localparam logic [REQ_USER_W-1:0] REQ_NONE = 2'd3;
   localparam logic [ADDR_W-1:0]     ADDR_TOP = {ADDR_W{1'b1}};

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [21:0] page_address, rest zero
   logic [REQ_USER_W-1:0] req_tuser  = '0;   // [1:0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [21:0] page_address_out, rest zero
   logic                  rsp_tuser;         // [0] none_free

   int mismatches;
   int pending;
   int burst_left = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   bitmap_page_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   bitmap_page_allocator_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // Offer one request word and hold it until the block takes it. Bursts of
   // random length are separated by random gaps; some gaps are zero so that
   // long back-to-back stretches also occur.
   task automatic offer(input logic [REQ_USER_W-1:0] kind, input logic [ADDR_W-1:0] addr);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'(addr);
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and hold until every outstanding response has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Pick a request kind from percentage thresholds; the remainder is the unused code.
   function automatic logic [REQ_USER_W-1:0] pick_kind(input int alloc_pct, input int free_pct,
                                                       input int mark_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct)                       return REQ_ALLOC;
      if (roll < alloc_pct + free_pct)            return REQ_FREE;
      if (roll < alloc_pct + free_pct + mark_pct) return REQ_MARK;
      return REQ_NONE;
   endfunction

   // Response side stalls on its own pattern: segments of always-ready, roughly
   // half-ready and mostly-stalled, plus one long hold-off early on so that the
   // block fills up and backs up the request side.
   initial begin : rsp_pattern
      int seg;
      int mode;
      int span;
      @(posedge clock);
      while (reset) @(posedge clock);
      for (seg = 0; ; seg++) begin
         mode = (seg == 3) ? 3 : $urandom_range(0, 2);
         span = (mode == 3) ? 400 : $urandom_range(20, 150);
         repeat (span) begin
            case (mode)
               0: begin
                  rsp_tready <= 1'b1;
               end
               1: begin
                  rsp_tready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_tready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_tready <= 1'b0;
               end
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [REQ_USER_W-1:0] kind;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: first allocations on an empty bitmap, top and bottom pages,
      // offsets inside a page, redundant mark and free, and the unused code.
      offer(REQ_ALLOC, '0);
      offer(REQ_ALLOC, ADDR_TOP);
      offer(REQ_MARK,  ADDR_TOP);                  // last page, top byte
      offer(REQ_FREE,  ADDR_W'(PAGE_BYTES - 1));   // page 0 by its last byte
      offer(REQ_ALLOC, '0);                        // hole at page 0 comes back first
      offer(REQ_NONE,  22'h2AAAAA);
      offer(REQ_MARK,  22'h155555);
      offer(REQ_MARK,  22'h155000);                // mark an already used page
      offer(REQ_FREE,  22'h3FF000);
      offer(REQ_FREE,  22'h3FF000);                // free an already free page
      offer(REQ_FREE,  ADDR_W'(PAGE_BYTES));       // page 1
      offer(REQ_ALLOC, 22'h155555);                // address ignored on allocate
      offer(REQ_NONE,  ADDR_TOP);
      offer(REQ_MARK,  '0);
      offer(REQ_ALLOC, '0);
      offer(REQ_FREE,  '0);
      offer(REQ_ALLOC, ADDR_TOP);
      drain();

      // Fill: mostly allocations, enough to exhaust every page and then keep
      // asking on a full bitmap.
      repeat (1200) begin
         kind = pick_kind(88, 2, 8);
         offer(kind, ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1)));
      end
      drain();

      // Churn: frees punch holes across the full bitmap, allocations must
      // refill the lowest hole each time.
      repeat (300) begin
         kind = pick_kind(35, 45, 10);
         offer(kind, ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1)));
      end
      drain();

      // Let any stray response surface before the verdict.
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest passing run.
   initial begin : watchdog
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: sim.f
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_ctl.sv
rtl/bpa_dp.sv
rtl/bitmap_page_allocator.sv
tb/sv/bitmap_page_allocator_checker.sv
tb/sv/bitmap_page_allocator_test.sv
